@@ hdl/ast_pkg.sv @@
// ----------------------------------------------------------------------------
// ast_pkg
// Shared types, constants and helpers for the adaptive staircase tracker.
// ----------------------------------------------------------------------------
package ast_pkg;

    localparam int LEVEL_W  = 16;
    localparam int REV_W    = 6;
    localparam int RUN_W    = 4;
    localparam int CFG_IDX_W = 3;

    localparam int UP_RUN_DEF   = 3;
    localparam int DOWN_RUN_DEF = 1;

    localparam logic [REV_W-1:0] REV_MAX = 6'd63;
    localparam logic [RUN_W-1:0] RUN_MAX = 4'd15;

    // reset values of the configuration registers
    localparam logic [LEVEL_W-1:0] COARSE_RST  = 16'd256;
    localparam logic [LEVEL_W-1:0] MEDIUM_RST  = 16'd128;
    localparam logic [LEVEL_W-1:0] FINE_RST    = 16'd64;
    localparam logic [LEVEL_W-1:0] FINEST_RST  = 16'd32;
    localparam logic [REV_W-1:0]   TARGET_RST  = 6'd8;
    localparam logic [LEVEL_W-1:0] FLOOR_RST   = 16'd0;
    localparam logic [LEVEL_W-1:0] CEILING_RST = 16'd25600;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_COARSE  = 3'd0,
        CFG_MEDIUM  = 3'd1,
        CFG_FINE    = 3'd2,
        CFG_FINEST  = 3'd3,
        CFG_TARGET  = 3'd4,
        CFG_FLOOR   = 3'd5,
        CFG_CEILING = 3'd6
    } cfg_idx_t;

    typedef enum logic [1:0] {
        CMD_RESPONSE = 2'd0,
        CMD_START    = 2'd1,
        CMD_COARSER  = 2'd2,
        CMD_FINER    = 2'd3
    } cmd_t;

    typedef enum logic [1:0] {
        DIR_NONE = 2'd0,
        DIR_UP   = 2'd1,
        DIR_DOWN = 2'd2
    } dir_t;

    typedef enum logic [1:0] {
        SEL_COARSE = 2'd0,
        SEL_MEDIUM = 2'd1,
        SEL_FINE   = 2'd2,
        SEL_FINEST = 2'd3
    } step_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_ADD,
        ST_ZCHK,
        ST_CLAMP,
        ST_DONE
    } state_t;

    function automatic step_sel_t select_for(input logic [REV_W-1:0] rev);
        step_sel_t sel;
        if (rev >= 6'd5)
            sel = SEL_FINEST;
        else if (rev >= 6'd3)
            sel = SEL_FINE;
        else if (rev >= 6'd1)
            sel = SEL_MEDIUM;
        else
            sel = SEL_COARSE;
        return sel;
    endfunction

    // saturating add of a small count to the reversal counter
    function automatic logic [REV_W-1:0] rev_add(input logic [REV_W-1:0] rev,
                                                 input logic [1:0] n);
        logic [REV_W:0] sum;
        sum = {1'b0, rev} + {{(REV_W-1){1'b0}}, n};
        return sum[REV_W] ? REV_MAX : sum[REV_W-1:0];
    endfunction

endpackage

@@ hdl/adaptive_staircase_tracker_core.sv @@
// ----------------------------------------------------------------------------
// adaptive_staircase_tracker_core
// Up-down staircase in Q8.8: one shared 17-bit adder under a small sequencer.
// ----------------------------------------------------------------------------
// Start, coarser and finer commands and non-moving responses go from decode
// to done; moving responses pass add, a zero check (correct ones) and clamp,
// re-adding per zero-level retry (at most 31), all through the one shared adder.
// Throughput: one item at a time; input is taken again once the result sits
// in the output register. Reset loads register defaults and clears tracker state.
module adaptive_staircase_tracker_core
    import ast_pkg::*;
#(
    parameter int UP_RUN   = UP_RUN_DEF,
    parameter int DOWN_RUN = DOWN_RUN_DEF
)
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [LEVEL_W-1:0]   cfg_wdata,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [23:0]          s_axis_tdata,  // correct, start_level, zero pad
    input  logic [1:0]           s_axis_tuser,  // command
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [47:0]          m_axis_tdata   // level, step_size, reversals,
                                                // complete, reversal_made,
                                                // step_warning, zero pad
);

    // configuration registers
    logic [LEVEL_W-1:0] coarse_reg, medium_reg, fine_reg, finest_reg;
    logic [LEVEL_W-1:0] floor_reg, ceiling_reg;
    logic [REV_W-1:0]   target_reg;

    // tracker state
    state_t             state_reg, state_next;
    logic [LEVEL_W-1:0] level_reg, level_next;
    step_sel_t          sel_reg, sel_next;
    logic [RUN_W-1:0]   crun_reg, crun_next;
    logic [RUN_W-1:0]   wrun_reg, wrun_next;
    dir_t               dir_reg, dir_next;
    logic [REV_W-1:0]   rev_reg, rev_next;

    // per-item working registers
    cmd_t               cmd_reg;
    logic               corr_reg;
    logic [LEVEL_W-1:0] start_reg;
    logic [LEVEL_W:0]   acc_reg, acc_next;
    logic               rflag_reg, rflag_next;
    logic               warn_reg, warn_next;
    logic               go_add_next;

    // output register
    logic               out_valid_reg, out_valid_next;
    logic [47:0]        out_data_reg;

    logic               in_xfer;
    logic               out_free;
    logic [LEVEL_W-1:0] step_cur;
    logic [LEVEL_W:0]   add_b;
    logic [LEVEL_W:0]   add_sum;
    logic               complete_now;
    logic               zero_rule;
    logic signed [LEVEL_W:0] acc_s, hi_s, lo_s, clip_hi;
    logic [LEVEL_W-1:0] clamped;
    logic [1:0]         rev_n;
    step_sel_t          sel_after2;
    logic [REV_W-1:0]   rev_after2;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign in_xfer       = s_axis_tvalid && s_axis_tready;
    assign out_free      = !out_valid_reg || m_axis_tready;
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;

    always_comb
    begin
        case (sel_reg)
            SEL_COARSE: step_cur = coarse_reg;
            SEL_MEDIUM: step_cur = medium_reg;
            SEL_FINE:   step_cur = fine_reg;
            SEL_FINEST: step_cur = finest_reg;
            default:    step_cur = coarse_reg;
        endcase
    end

    // shared adder: level plus or minus the current step
    assign add_b   = corr_reg ? {step_cur[LEVEL_W-1], step_cur}
                              : ~{step_cur[LEVEL_W-1], step_cur};
    assign add_sum = {level_reg[LEVEL_W-1], level_reg} + add_b
                     + {{LEVEL_W{1'b0}}, !corr_reg};

    assign complete_now = (rev_reg >= target_reg);
    assign acc_s     = acc_reg;
    assign hi_s      = {ceiling_reg[LEVEL_W-1], ceiling_reg};
    assign lo_s      = {floor_reg[LEVEL_W-1], floor_reg};
    assign clip_hi   = (acc_s > hi_s) ? hi_s : acc_s;
    assign clamped   = (clip_hi < lo_s) ? floor_reg : clip_hi[LEVEL_W-1:0];
    assign zero_rule = (floor_reg == '0) && (acc_s <= 0);
    assign rev_after2 = rev_add(rev_reg, 2'd2);
    assign sel_after2 = select_for(rev_after2);
    assign rev_n     = (dir_reg == DIR_UP) ? 2'd2 : 2'd1;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                    state_next = ST_DECODE;
            end
            ST_DECODE:
            begin
                state_next = go_add_next ? ST_ADD : ST_DONE;
            end
            ST_ADD:
            begin
                state_next = corr_reg ? ST_ZCHK : ST_CLAMP;
            end
            ST_ZCHK:
            begin
                if (!zero_rule)
                    state_next = ST_CLAMP;
                else if (rev_after2 >= target_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_ADD;
            end
            ST_CLAMP:
            begin
                state_next = ST_DONE;
            end
            ST_DONE:
            begin
                if (out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // datapath updates
    always_comb
    begin
        level_next     = level_reg;
        sel_next       = sel_reg;
        crun_next      = crun_reg;
        wrun_next      = wrun_reg;
        dir_next       = dir_reg;
        rev_next       = rev_reg;
        acc_next       = acc_reg;
        rflag_next     = rflag_reg;
        warn_next      = warn_reg;
        go_add_next    = 1'b0;
        out_valid_next = out_valid_reg && !m_axis_tready;
        case (state_reg)
            ST_DECODE:
            begin
                rflag_next = 1'b0;
                warn_next  = 1'b0;
                case (cmd_reg)
                    CMD_START:
                    begin
                        level_next = start_reg;
                        rev_next   = '0;
                        crun_next  = '0;
                        wrun_next  = '0;
                        sel_next   = SEL_COARSE;
                        dir_next   = DIR_NONE;
                    end
                    CMD_COARSER, CMD_FINER:
                    begin
                        if (cmd_reg == CMD_COARSER)
                            rev_next = (rev_reg >= {4'd0, rev_n})
                                       ? rev_reg - {4'd0, rev_n} : '0;
                        else
                            rev_next = rev_add(rev_reg, rev_n);
                        dir_next  = DIR_UP;
                        crun_next = '0;
                        wrun_next = '0;
                        sel_next  = select_for(rev_next);
                    end
                    CMD_RESPONSE:
                    begin
                        if (!complete_now)
                        begin
                            if (corr_reg)
                            begin
                                wrun_next = '0;
                                crun_next = (crun_reg < RUN_MAX) ? crun_reg + RUN_W'(1)
                                                                 : crun_reg;
                                go_add_next = (crun_next >= RUN_W'(UP_RUN));
                            end
                            else
                            begin
                                crun_next = '0;
                                wrun_next = (wrun_reg < RUN_MAX) ? wrun_reg + RUN_W'(1)
                                                                 : wrun_reg;
                                go_add_next = (wrun_next >= RUN_W'(DOWN_RUN));
                            end
                        end
                    end
                    default:
                    begin
                        go_add_next = 1'b0;
                    end
                endcase
            end
            ST_ADD:
            begin
                acc_next = add_sum;
            end
            ST_ZCHK:
            begin
                if (zero_rule)
                begin
                    rev_next = rev_after2;
                    sel_next = sel_after2;
                    if (rev_after2 >= target_reg)
                        warn_next = 1'b1;
                end
            end
            ST_CLAMP:
            begin
                level_next = clamped;
                if ((corr_reg && dir_reg == DIR_DOWN) || (!corr_reg && dir_reg == DIR_UP))
                begin
                    rev_next   = rev_add(rev_reg, 2'd1);
                    rflag_next = 1'b1;
                    sel_next   = select_for(rev_next);
                end
                if (corr_reg)
                begin
                    dir_next  = DIR_UP;
                    crun_next = '0;
                end
                else
                begin
                    dir_next  = DIR_DOWN;
                    wrun_next = '0;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                    out_valid_next = 1'b1;
            end
            default:
            begin
                out_valid_next = out_valid_reg && !m_axis_tready;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            coarse_reg  <= COARSE_RST;
            medium_reg  <= MEDIUM_RST;
            fine_reg    <= FINE_RST;
            finest_reg  <= FINEST_RST;
            target_reg  <= TARGET_RST;
            floor_reg   <= FLOOR_RST;
            ceiling_reg <= CEILING_RST;
        end
        else if (cfg_we)
        begin
            case (cfg_idx_t'(cfg_index))
                CFG_COARSE:  coarse_reg  <= cfg_wdata;
                CFG_MEDIUM:  medium_reg  <= cfg_wdata;
                CFG_FINE:    fine_reg    <= cfg_wdata;
                CFG_FINEST:  finest_reg  <= cfg_wdata;
                CFG_TARGET:  target_reg  <= cfg_wdata[REV_W-1:0];
                CFG_FLOOR:   floor_reg   <= cfg_wdata;
                CFG_CEILING: ceiling_reg <= cfg_wdata;
                default:     target_reg  <= target_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            level_reg     <= '0;
            sel_reg       <= SEL_COARSE;
            crun_reg      <= '0;
            wrun_reg      <= '0;
            dir_reg       <= DIR_NONE;
            rev_reg       <= '0;
            rflag_reg     <= 1'b0;
            warn_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            level_reg     <= level_next;
            sel_reg       <= sel_next;
            crun_reg      <= crun_next;
            wrun_reg      <= wrun_next;
            dir_reg       <= dir_next;
            rev_reg       <= rev_next;
            rflag_reg     <= rflag_next;
            warn_reg      <= warn_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (in_xfer)
        begin
            cmd_reg   <= cmd_t'(s_axis_tuser);
            corr_reg  <= s_axis_tdata[0];
            start_reg <= s_axis_tdata[LEVEL_W:1];
        end
        acc_reg <= acc_next;
        if (state_reg == ST_DONE && out_free)
            out_data_reg <= {7'd0, warn_reg, rflag_reg, complete_now, rev_reg,
                             step_cur, level_reg};
    end

endmodule

@@ hdl/ast_checker.sv @@
// ----------------------------------------------------------------------------
// ast_checker
// Port-level checks for the staircase tracker, bound to the tracker core module.
// ----------------------------------------------------------------------------
module ast_checker
(
    input logic        clk,
    input logic        rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [47:0] m_axis_tdata
);

    // one item in flight: input closes right after a transfer
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input accepted while an item is in work");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("stalled result changed");

    // the zero-level warning only ends a run
    a_warn_complete: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[40] |-> m_axis_tdata[38] && !m_axis_tdata[39])
        else $error("warning without completion or with reversal");

    a_rev_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[39] |-> m_axis_tdata[37:32] != 6'd0)
        else $error("reversal flagged with zero count");

endmodule

bind adaptive_staircase_tracker_core ast_checker u_ast_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
);

@@ test/adaptive_staircase_tracker_core_tb.sv @@
// ----------------------------------------------------------------------------
// adaptive_staircase_tracker_core_tb
// Drives trials and commands into the staircase tracker and checks each
// output against a typed row's expected result or a Q8.8 software tracker
// kept in step with the block's registers. Directed trials first, then
// random phases under several register settings, bursty input, stalling output.
// ----------------------------------------------------------------------------
module adaptive_staircase_tracker_core_tb;

    import ast_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int NUM_DIRECTED   = 24;
    localparam int NUM_PHASES     = 8;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int TAIL_CYCLES    = 80;

    typedef struct packed {
        cmd_t        cmd;
        logic        correct;
        logic [15:0] start_level;
    } trial_t;

    // layout matches m_axis_tdata[40:0], top field first
    typedef struct packed {
        logic        step_warning;
        logic        reversal_made;
        logic        complete;
        logic [5:0]  reversals;
        logic [15:0] step_size;
        logic [15:0] level;
    } track_out_t;

    typedef struct packed {
        trial_t     stim;
        logic       typed;
        track_out_t want;
    } directed_row_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        cfg_we = 1'b0;
    logic [2:0]  cfg_index = '0;
    logic [15:0] cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [23:0] s_axis_tdata = '0;  // correct, start_level, zero pad
    logic [1:0]  s_axis_tuser = '0;  // command
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [47:0] m_axis_tdata;       // level, step_size, reversals, complete,
                                     // reversal_made, step_warning, zero pad

    adaptive_staircase_tracker_core dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // software copy of the tracker registers and state
    logic signed [15:0] step_reg [4] = '{COARSE_RST, MEDIUM_RST, FINE_RST, FINEST_RST};
    logic [5:0]         rev_target = TARGET_RST;
    logic signed [15:0] floor_lvl = FLOOR_RST;
    logic signed [15:0] ceil_lvl = CEILING_RST;

    logic signed [15:0] trk_level = '0;
    step_sel_t          trk_sel = SEL_COARSE;
    logic [3:0]         trk_crun = '0;
    logic [3:0]         trk_wrun = '0;
    dir_t               trk_dir = DIR_NONE;
    logic [5:0]         trk_rev = '0;

    track_out_t track_outcomes_due [$];

    logic       drv_typed = 1'b0;
    track_out_t drv_want = '0;
    int         burst_left = 0;
    int         rx_mode = 0;
    int         rx_left = 0;
    int         idle_cycles = 0;

    int fail_count = 0;
    int trials_in = 0;
    int outputs_checked = 0;
    int reversals_seen = 0;
    int completes_seen = 0;
    int warnings_seen = 0;
    int cfg_writes = 0;

    directed_row_t directed_rows [NUM_DIRECTED] = '{
        // straight after reset: a wrong answer pins the level at the zero floor
        '{'{CMD_RESPONSE, 1'b0, 16'h0000}, 1'b1,
          '{level: 16'h0000, step_size: 16'h0100, default: '0}},
        '{'{CMD_START, 1'b0, 16'h7FFF}, 1'b1,
          '{level: 16'h7FFF, step_size: 16'h0100, default: '0}},
        '{'{CMD_RESPONSE, 1'b1, 16'h0000}, 1'b1,
          '{level: 16'h7FFF, step_size: 16'h0100, default: '0}},
        '{'{CMD_RESPONSE, 1'b1, 16'h0000}, 1'b1,
          '{level: 16'h7FFF, step_size: 16'h0100, default: '0}},
        // third correct: move up, clamped to the ceiling
        '{'{CMD_RESPONSE, 1'b1, 16'h0000}, 1'b1,
          '{level: 16'h6400, step_size: 16'h0100, default: '0}},
        // first reversal switches to the medium step
        '{'{CMD_RESPONSE, 1'b0, 16'h0000}, 1'b1,
          '{level: 16'h6300, step_size: 16'h0080, reversals: 6'd1, reversal_made: 1'b1,
            default: '0}},
        '{'{CMD_RESPONSE, 1'b1, 16'h0000}, 1'b0, '0},
        '{'{CMD_RESPONSE, 1'b1, 16'h0000}, 1'b0, '0},
        '{'{CMD_RESPONSE, 1'b1, 16'h0000}, 1'b0, '0},
        '{'{CMD_START, 1'b1, 16'h8000}, 1'b1,
          '{level: 16'h8000, step_size: 16'h0100, default: '0}},
        '{'{CMD_RESPONSE, 1'b0, 16'h0000}, 1'b1,
          '{level: 16'h0000, step_size: 16'h0100, default: '0}},
        '{'{CMD_START, 1'b0, 16'hFC00}, 1'b1,
          '{level: 16'hFC00, step_size: 16'h0100, default: '0}},
        '{'{CMD_RESPONSE, 1'b1, 16'h0000}, 1'b0, '0},
        '{'{CMD_RESPONSE, 1'b1, 16'h0000}, 1'b0, '0},
        // zero-level rule walks through all steps and ends the run
        '{'{CMD_RESPONSE, 1'b1, 16'h0000}, 1'b1,
          '{level: 16'hFC00, step_size: 16'h0020, reversals: 6'd8, complete: 1'b1,
            step_warning: 1'b1, default: '0}},
        // run complete: response ignored
        '{'{CMD_RESPONSE, 1'b0, 16'h0000}, 1'b1,
          '{level: 16'hFC00, step_size: 16'h0020, reversals: 6'd8, complete: 1'b1,
            default: '0}},
        '{'{CMD_COARSER, 1'b0, 16'h0000}, 1'b0, '0},
        '{'{CMD_COARSER, 1'b1, 16'h0000}, 1'b0, '0},
        '{'{CMD_FINER, 1'b0, 16'h0000}, 1'b0, '0},
        '{'{CMD_FINER, 1'b1, 16'h0000}, 1'b0, '0},
        '{'{CMD_START, 1'b0, 16'h0100}, 1'b1,
          '{level: 16'h0100, step_size: 16'h0100, default: '0}},
        // coarser at zero reversals stays at zero
        '{'{CMD_COARSER, 1'b0, 16'h0000}, 1'b1,
          '{level: 16'h0100, step_size: 16'h0100, default: '0}},
        '{'{CMD_FINER, 1'b0, 16'h0000}, 1'b0, '0},
        '{'{CMD_RESPONSE, 1'b0, 16'h0000}, 1'b0, '0}
    };

    function automatic logic [5:0] sat_rev(logic [5:0] r, int n);
        int s;
        s = int'(r) + n;
        return (s > 63) ? 6'd63 : 6'(s);
    endfunction

    function automatic step_sel_t step_for_reversals(logic [5:0] r);
        if (r >= 6'd5)
            return SEL_FINEST;
        if (r >= 6'd3)
            return SEL_FINE;
        if (r >= 6'd1)
            return SEL_MEDIUM;
        return SEL_COARSE;
    endfunction

    function automatic int active_step();
        return int'(step_reg[trk_sel]);
    endfunction

    // ceiling first, so the floor wins when the two cross
    function automatic int clamp_level(int v);
        if (v > int'(ceil_lvl))
            v = int'(ceil_lvl);
        if (v < int'(floor_lvl))
            v = int'(floor_lvl);
        return v;
    endfunction

    function automatic track_out_t staircase_update(trial_t t);
        track_out_t res;
        int         n;
        int         nxt;
        logic       rflag;
        logic       warn;
        rflag = 1'b0;
        warn = 1'b0;
        case (t.cmd)
            CMD_START:
            begin
                trk_level = t.start_level;
                trk_rev = '0;
                trk_crun = '0;
                trk_wrun = '0;
                trk_sel = SEL_COARSE;
                trk_dir = DIR_NONE;
            end
            CMD_COARSER, CMD_FINER:
            begin
                n = (trk_dir == DIR_UP) ? 2 : 1;
                if (t.cmd == CMD_COARSER)
                    trk_rev = (int'(trk_rev) >= n) ? 6'(int'(trk_rev) - n) : 6'd0;
                else
                    trk_rev = sat_rev(trk_rev, n);
                trk_dir = DIR_UP;
                trk_crun = '0;
                trk_wrun = '0;
                trk_sel = step_for_reversals(trk_rev);
            end
            default:
            begin
                if (trk_rev < rev_target)
                begin
                    if (t.correct)
                    begin
                        trk_wrun = '0;
                        if (trk_crun != RUN_MAX)
                            trk_crun = trk_crun + 4'd1;
                        if (trk_crun >= UP_RUN_DEF)
                        begin
                            nxt = int'(trk_level) + active_step();
                            // zero floor: keep refining until the move stays above zero or the run ends
                            for (int i = 0; i < 64; i++)
                            begin
                                if (floor_lvl != 0 || nxt > 0)
                                    break;
                                trk_rev = sat_rev(trk_rev, 2);
                                trk_sel = step_for_reversals(trk_rev);
                                if (trk_rev >= rev_target)
                                begin
                                    warn = 1'b1;
                                    break;
                                end
                                nxt = int'(trk_level) + active_step();
                            end
                            if (!warn)
                            begin
                                trk_level = 16'(clamp_level(nxt));
                                if (trk_dir == DIR_DOWN)
                                begin
                                    trk_rev = sat_rev(trk_rev, 1);
                                    rflag = 1'b1;
                                end
                                trk_dir = DIR_UP;
                                trk_crun = '0;
                            end
                        end
                    end
                    else
                    begin
                        trk_crun = '0;
                        if (trk_wrun != RUN_MAX)
                            trk_wrun = trk_wrun + 4'd1;
                        if (trk_wrun >= DOWN_RUN_DEF)
                        begin
                            trk_level = 16'(clamp_level(int'(trk_level) - active_step()));
                            if (trk_dir == DIR_UP)
                            begin
                                trk_rev = sat_rev(trk_rev, 1);
                                rflag = 1'b1;
                            end
                            trk_dir = DIR_DOWN;
                            trk_wrun = '0;
                        end
                    end
                    if (rflag)
                        trk_sel = step_for_reversals(trk_rev);
                end
            end
        endcase
        res.level = trk_level;
        res.step_size = step_reg[trk_sel];
        res.reversals = trk_rev;
        res.complete = (trk_rev >= rev_target);
        res.reversal_made = rflag;
        res.step_warning = warn;
        return res;
    endfunction

    function automatic void cmp_field(string name, logic [15:0] want, logic [15:0] got);
        if (got !== want)
        begin
            $error("%s mismatch: expected 0x%h, got 0x%h", name, want, got);
            fail_count++;
        end
    endfunction

    // input side: predict on every accepted transfer
    always @(posedge clk)
    begin
        trial_t     seen;
        track_out_t calc;
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            seen.cmd = cmd_t'(s_axis_tuser);
            seen.correct = s_axis_tdata[0];
            seen.start_level = s_axis_tdata[16:1];
            calc = staircase_update(seen);
            track_outcomes_due.push_back(drv_typed ? drv_want : calc);
            trials_in++;
        end
    end

    // output side: compare against the oldest pending outcome
    always @(posedge clk)
    begin
        track_out_t got;
        track_out_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = track_out_t'(m_axis_tdata[40:0]);
            if (track_outcomes_due.size() == 0)
            begin
                $error("output transfer with nothing pending: 0x%h", m_axis_tdata);
                fail_count++;
            end
            else
            begin
                want = track_outcomes_due.pop_front();
                cmp_field("level", want.level, got.level);
                cmp_field("step_size", want.step_size, got.step_size);
                cmp_field("reversals", 16'(want.reversals), 16'(got.reversals));
                cmp_field("complete", 16'(want.complete), 16'(got.complete));
                cmp_field("reversal_made", 16'(want.reversal_made), 16'(got.reversal_made));
                cmp_field("step_warning", 16'(want.step_warning), 16'(got.step_warning));
                outputs_checked++;
                reversals_seen += got.reversal_made;
                completes_seen += got.complete;
                warnings_seen += got.step_warning;
            end
        end
    end

    // receiver: modes of always-ready, coin-flip and long stalls
    always @(posedge clk)
    begin
        if (rx_left == 0)
        begin
            rx_mode = $urandom_range(0, 2);
            rx_left = $urandom_range(8, 120);
        end
        else
            rx_left = rx_left - 1;
        case (rx_mode)
            0: m_axis_tready <= 1'b1;
            1: m_axis_tready <= 1'($urandom_range(0, 1));
            default: m_axis_tready <= ($urandom_range(0, 5) == 0);
        endcase
    end

    always @(posedge clk)
    begin
        if (!rst_n || cfg_we || (s_axis_tvalid && s_axis_tready) ||
            (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $error("no transfer for %0d cycles, %0d outputs outstanding",
                   idle_cycles, track_outcomes_due.size());
            $display("CHECKS FAILED");
            $finish;
        end
        else
            idle_cycles <= idle_cycles + 1;
    end

    // call right after a rising edge; returns at the edge of the transfer
    task automatic offer_trial(trial_t t, logic typed, track_out_t want);
        int gap;
        if (burst_left == 0)
        begin
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
            burst_left = ($urandom_range(0, 7) == 0) ? 40 : $urandom_range(1, 16);
            if (gap > 0)
            begin
                s_axis_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= {7'b0, t.start_level, t.correct};
        s_axis_tuser <= t.cmd;
        drv_typed <= typed;
        drv_want <= want;
        @(posedge clk);
        while (!s_axis_tready)
            @(posedge clk);
    endtask

    task automatic run_trials(int count);
        trial_t t;
        int     pick;
        for (int i = 0; i < count; i++)
        begin
            pick = $urandom_range(0, 99);
            t.correct = ($urandom_range(0, 99) < 72);
            t.start_level = 16'($urandom);
            if (pick < 6)
            begin
                t.cmd = CMD_START;
                if ($urandom_range(0, 3) != 0)
                    t.start_level = 16'(int'($urandom_range(0, 16'h3000)) - 16'h0400);
            end
            else if (pick < 11)
                t.cmd = CMD_COARSER;
            else if (pick < 16)
                t.cmd = CMD_FINER;
            else
                t.cmd = CMD_RESPONSE;
            offer_trial(t, 1'b0, '0);
        end
    endtask

    task automatic wait_idle();
        s_axis_tvalid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (track_outcomes_due.size() != 0);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(cfg_idx_t idx, logic [15:0] val);
        @(posedge clk);
        cfg_we <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        case (idx)
            CFG_COARSE:  step_reg[SEL_COARSE] = val;
            CFG_MEDIUM:  step_reg[SEL_MEDIUM] = val;
            CFG_FINE:    step_reg[SEL_FINE] = val;
            CFG_FINEST:  step_reg[SEL_FINEST] = val;
            CFG_TARGET:  rev_target = val[5:0];
            CFG_FLOOR:   floor_lvl = val;
            CFG_CEILING: ceil_lvl = val;
            default: ;
        endcase
        cfg_writes++;
    endtask

    initial
    begin
        logic [15:0] regs [7];
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
            offer_trial(directed_rows[i].stim, directed_rows[i].typed, directed_rows[i].want);
        run_trials(100);
        wait_idle();

        for (int p = 1; p < NUM_PHASES; p++)
        begin
            case (p)
                1: regs = '{16'h7FFF, 16'h8000, 16'h0000, 16'h0001, 16'd63, 16'h8000, 16'h7FFF};
                // negative steps on a zero floor keep the zero-level rule busy
                2: regs = '{16'hFF00, 16'hFF80, 16'hFFC0, 16'hFFE0, 16'd63, 16'h0000, 16'h6400};
                // floor above ceiling, run ends on the first reversal
                3: regs = '{COARSE_RST, MEDIUM_RST, FINE_RST, FINEST_RST, 16'd1,
                            16'h1000, 16'h0800};
                NUM_PHASES - 1:
                    regs = '{COARSE_RST, MEDIUM_RST, FINE_RST, FINEST_RST, 16'(TARGET_RST),
                             FLOOR_RST, CEILING_RST};
                default:
                begin
                    foreach (regs[i])
                        regs[i] = ($urandom_range(0, 2) == 0) ? 16'($urandom) :
                                  16'(int'($urandom_range(0, 16'h0300)) - 16'h0080);
                    regs[CFG_TARGET] = (p == 4) ? 16'd0 : 16'($urandom_range(1, 63));
                    regs[CFG_FLOOR] = $urandom_range(0, 1) ? 16'h0000 :
                                      16'(int'($urandom_range(0, 16'h1000)) - 16'h0800);
                    regs[CFG_CEILING] = 16'($urandom_range(16'h0400, 16'h6400));
                end
            endcase
            foreach (regs[i])
                write_reg(cfg_idx_t'(i), regs[i]);
            @(posedge clk);
            cfg_we <= 1'b0;
            run_trials((p == 4) ? 60 : 100);
            wait_idle();
        end

        repeat (TAIL_CYCLES) @(posedge clk);
        $display("Covered %0d trials, %0d outputs checked, %0d register settings (%0d writes).",
                 trials_in, outputs_checked, NUM_PHASES, cfg_writes);
        $display("Observed %0d reversals, %0d complete outputs, %0d zero-level warnings.",
                 reversals_seen, completes_seen, warnings_seen);
        if (fail_count == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule

@@ files.f @@
hdl/ast_pkg.sv
hdl/adaptive_staircase_tracker_core.sv
hdl/ast_checker.sv
test/adaptive_staircase_tracker_core_tb.sv
